// ===== src/prq_pkg.sv =====
// Shared types, codes and sizes for the priority ready-queue scheduler.
package prq_pkg;

    localparam int NUM_LEVELS  = 32;
    localparam int NUM_THREADS = 16;
    localparam int LVL_W       = 5;
    localparam int THR_W       = 4;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_SCHEDULE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_ALREADY   = 2'd2;
    localparam logic [1:0] ST_NOT_READY = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [THR_W-1:0] thread_id;
        logic [LVL_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             switch_now;
        logic [THR_W-1:0] next_thread;
        logic [THR_W-1:0] prev_thread;
        logic             prev_valid;
        logic [LVL_W-1:0] run_priority;
    } rsp_t;

    // Clamp a level to the lowest existing priority.
    function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] p);
        logic [LVL_W-1:0] r;
        r = p;
        if (int'(p) >= NUM_LEVELS) begin
            r = LVL_W'(NUM_LEVELS - 1);
        end
        return r;
    endfunction

endpackage

// ===== src/prq_lowest.sv =====
// Priority encoder: index of the lowest set bit of the ready bitmap.
module prq_lowest (
    input  logic [prq_pkg::NUM_LEVELS-1:0] mask,
    output logic                           any,
    output logic [prq_pkg::LVL_W-1:0]      idx
);

    logic [prq_pkg::NUM_LEVELS-1:0] onehot;

    // Isolate the lowest set bit, then OR together the indexes of set bits.
    assign onehot = mask & (~mask + prq_pkg::NUM_LEVELS'(1));
    assign any    = |mask;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < prq_pkg::NUM_LEVELS; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | prq_pkg::LVL_W'(i);
            end
        end
    end

endmodule

// ===== src/prq_core.sv =====
// Scheduler state tables and the single-pass update for one command word.
module prq_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  prq_pkg::req_t req,
    output prq_pkg::rsp_t rsp
);

    localparam int NL = prq_pkg::NUM_LEVELS;
    localparam int NT = prq_pkg::NUM_THREADS;
    localparam int LW = prq_pkg::LVL_W;
    localparam int TW = prq_pkg::THR_W;

    // Control state
    logic [NL-1:0] bitmap_reg,    bitmap_next;
    logic [NT-1:0] ready_reg,     ready_next;
    logic [TW-1:0] run_thread_reg, run_thread_next;
    logic          run_valid_reg,  run_valid_next;
    logic [LW-1:0] run_level_reg,  run_level_next;

    // Payload tables
    logic [TW-1:0] head_reg  [NL];
    logic [TW-1:0] tail_reg  [NL];
    logic [TW-1:0] lnext_reg [NT];
    logic [TW-1:0] lprev_reg [NT];
    logic [LW-1:0] level_reg [NT];

    logic [TW-1:0] t;
    logic          t_ok;
    logic [LW-1:0] ins_p, rm_p, sch_p;
    logic          sch_any;
    logic [LW-1:0] head_addr, tail_addr;
    logic [TW-1:0] head_rd, tail_rd, n_rd, pr_rd;
    logic          t_ready;

    logic          head_we;  logic [LW-1:0] head_wa;  logic [TW-1:0] head_wd;
    logic          tail_we;  logic [LW-1:0] tail_wa;  logic [TW-1:0] tail_wd;
    logic          lna_we;   logic [TW-1:0] lna_wa;   logic [TW-1:0] lna_wd;
    logic          lnb_we;
    logic          lp_we;    logic [TW-1:0] lp_wa;    logic [TW-1:0] lp_wd;
    logic          lvl_we;

    prq_lowest u_lowest (
        .mask (bitmap_reg),
        .any  (sch_any),
        .idx  (sch_p)
    );

    assign t       = req.thread_id;
    assign t_ok    = (int'(t) < NT);
    assign ins_p   = prq_pkg::sat_level(req.priority_req);
    assign t_ready = t_ok && ready_reg[t];
    assign rm_p    = prq_pkg::sat_level(level_reg[t]);

    assign head_addr = (req.cmd == prq_pkg::CMD_SCHEDULE) ? sch_p : rm_p;
    assign tail_addr = (req.cmd == prq_pkg::CMD_INSERT)   ? ins_p : rm_p;
    assign head_rd   = head_reg[head_addr];
    assign tail_rd   = tail_reg[tail_addr];
    assign n_rd      = lnext_reg[t];
    assign pr_rd     = lprev_reg[t];

    always_comb
    begin
        bitmap_next     = bitmap_reg;
        ready_next      = ready_reg;
        run_thread_next = run_thread_reg;
        run_valid_next  = run_valid_reg;
        run_level_next  = run_level_reg;
        head_we = 1'b0; head_wa = ins_p; head_wd = t;
        tail_we = 1'b0; tail_wa = ins_p; tail_wd = t;
        lna_we  = 1'b0; lna_wa  = tail_rd; lna_wd = t;
        lnb_we  = 1'b0;
        lp_we   = 1'b0; lp_wa   = t;     lp_wd  = t;
        lvl_we  = 1'b0;
        rsp     = '0;
        rsp.status = prq_pkg::ST_OK;

        case (req.cmd)
            prq_pkg::CMD_INSERT:
            begin
                if (!t_ok)
                begin
                    rsp.status = prq_pkg::ST_NOT_READY;
                end
                else if (t_ready)
                begin
                    rsp.status = prq_pkg::ST_ALREADY;
                end
                else
                begin
                    // Append at the tail; a fresh level starts with t as head.
                    if (bitmap_reg[ins_p])
                    begin
                        lna_we = (int'(tail_rd) < NT);
                        lp_wd  = tail_rd;
                    end
                    else
                    begin
                        head_we = 1'b1;
                    end
                    lp_we   = 1'b1;
                    lnb_we  = 1'b1;
                    tail_we = 1'b1;
                    lvl_we  = 1'b1;
                    ready_next[t]      = 1'b1;
                    bitmap_next[ins_p] = 1'b1;
                end
            end
            prq_pkg::CMD_REMOVE:
            begin
                if (!t_ready)
                begin
                    rsp.status = prq_pkg::ST_NOT_READY;
                end
                else
                begin
                    // Unlink t from head, tail or middle of its level.
                    if (head_rd == t && tail_rd == t)
                    begin
                        bitmap_next[rm_p] = 1'b0;
                    end
                    else if (head_rd == t)
                    begin
                        head_we = 1'b1;
                        head_wa = rm_p;
                        head_wd = n_rd;
                    end
                    else if (tail_rd == t)
                    begin
                        tail_we = 1'b1;
                        tail_wa = rm_p;
                        tail_wd = pr_rd;
                    end
                    else
                    begin
                        lna_we = (int'(pr_rd) < NT);
                        lna_wa = pr_rd;
                        lna_wd = n_rd;
                        lp_we  = (int'(n_rd) < NT);
                        lp_wa  = n_rd;
                        lp_wd  = pr_rd;
                    end
                    ready_next[t] = 1'b0;
                end
            end
            prq_pkg::CMD_SCHEDULE:
            begin
                if (!sch_any)
                begin
                    rsp.status = prq_pkg::ST_EMPTY;
                end
                else if (!run_valid_reg || head_rd != run_thread_reg)
                begin
                    rsp.switch_now  = 1'b1;
                    rsp.next_thread = head_rd;
                    rsp.prev_thread = run_thread_reg;
                    rsp.prev_valid  = run_valid_reg;
                    run_level_next  = sch_p;
                    run_thread_next = head_rd;
                    run_valid_next  = 1'b1;
                end
            end
            default:
            begin
                rsp.status = prq_pkg::ST_OK;
            end
        endcase

        rsp.run_priority = run_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg     <= '0;
            ready_reg      <= '0;
            run_thread_reg <= '0;
            run_valid_reg  <= 1'b0;
            run_level_reg  <= LW'(NL - 1);
        end
        else if (fire)
        begin
            bitmap_reg     <= bitmap_next;
            ready_reg      <= ready_next;
            run_thread_reg <= run_thread_next;
            run_valid_reg  <= run_valid_next;
            run_level_reg  <= run_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (head_we)
            begin
                head_reg[head_wa] <= head_wd;
            end
            if (tail_we)
            begin
                tail_reg[tail_wa] <= tail_wd;
            end
            if (lna_we)
            begin
                lnext_reg[lna_wa] <= lna_wd;
            end
            // Self link of the new tail wins over the predecessor link.
            if (lnb_we)
            begin
                lnext_reg[t] <= t;
            end
            if (lp_we)
            begin
                lprev_reg[lp_wa] <= lp_wd;
            end
            if (lvl_we)
            begin
                level_reg[t] <= ins_p;
            end
        end
    end

endmodule

// ===== src/priority_ready_queue_scheduler_unit.sv =====
// Top level: input register, scheduler core and result register.
// Command words are registered on input and results on output.
// Throughput: one command word per cycle unless rsp_ready stalls; the
//   scheduler tables and 32-bit lowest-level encoder update in one pass.
// Reset (rst_n, asynchronous, active low): empties the ready bitmap, clears
//   the ready flags and the running thread, sets running priority to 31.
module priority_ready_queue_scheduler_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  prq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output prq_pkg::rsp_t rsp
);

    // Input stage: holds one accepted command word.
    logic          in_valid_reg, in_valid_next;
    prq_pkg::req_t in_req_reg;

    // Result stage: holds one finished result word.
    logic          out_valid_reg, out_valid_next;
    prq_pkg::rsp_t out_rsp_reg;

    logic          out_load;
    logic          fire;
    logic          req_take;
    prq_pkg::rsp_t core_rsp;

    // Advance into the result stage whenever it is empty or being drained.
    assign out_load  = !out_valid_reg || rsp_ready;
    // Process the held word and commit its state update in the same edge.
    assign fire      = in_valid_reg && out_load;
    // Take a new word while the input stage is empty or moving on.
    assign req_ready = !in_valid_reg || out_load;
    assign req_take  = req_valid && req_ready;

    assign in_valid_next  = req_take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !rsp_ready);

    prq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_req_reg),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on a handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_req_reg <= req;
        end
        if (fire)
        begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    // A stalled result keeps the held command word in the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !rsp_ready)
            |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("input stage lost a word while the result stalled");

    // Every processed word shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rsp_valid && rsp == $past(core_rsp)))
        else $error("processed word did not reach the result stage");

    // A switch only comes with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.switch_now) |-> (rsp.status == prq_pkg::ST_OK))
        else $error("switch reported with an error status");

    // Without a switch the thread fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.switch_now)
            |-> (rsp.next_thread == '0 && rsp.prev_thread == '0 && !rsp.prev_valid))
        else $error("thread fields set without a switch");

endmodule
